// ===== rtl/cdms_pkg.sv =====
// Shared types, constants and register codes for the color difference median smoother.
package cdms_pkg;

   // Line store depth and the address width that follows from it
   localparam int MAX_WIDTH = 4096;
   localparam int ADDR_W    = $clog2(MAX_WIDTH);

   // Field widths
   localparam int PIX_W      = 16;
   localparam int DIFF_W     = PIX_W + 1;
   localparam int SUM_W      = PIX_W + 2;
   localparam int ROW_W      = 16;
   localparam int COL_W      = 12;
   localparam int FW_W       = 13;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int WIN_DIM    = 3;
   localparam int WIN_N      = WIN_DIM * WIN_DIM;

   // Register reset values and lower limits
   localparam logic [FW_W-1:0]  FRAME_WIDTH_RESET  = FW_W'(4096);
   localparam logic [ROW_W-1:0] FRAME_HEIGHT_RESET = ROW_W'(3);
   localparam logic [FW_W-1:0]  FRAME_WIDTH_MIN    = FW_W'(3);
   localparam logic [ROW_W-1:0] FRAME_HEIGHT_MIN   = ROW_W'(3);

   // Register index, taken from paddr bit 2
   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_type;

   typedef logic signed [DIFF_W-1:0] diff_type;

   // One stored pixel: R-G, B-G and G
   typedef struct packed {
      diff_type         rd;
      diff_type         bd;
      logic [PIX_W-1:0] g;
   } triple_type;

   // One line store entry: the two rows above at the same column
   typedef struct packed {
      triple_type up;
      triple_type mid;
   } line_pair_type;

   typedef struct packed {
      logic [FW_W-1:0]  frame_width;
      logic [ROW_W-1:0] frame_height;
   } cfg_type;

   // Full window handed to the median pipeline, index = row*3 + col
   typedef struct packed {
      diff_type [WIN_N-1:0] rd;
      diff_type [WIN_N-1:0] bd;
      logic [PIX_W-1:0]     gc;
      logic [ROW_W-1:0]     row;
      logic [COL_W-1:0]     col;
   } win_type;

endpackage

// ===== rtl/cdms_csr.sv =====
// Configuration registers behind the APB-style port.
module cdms_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [cdms_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [cdms_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [cdms_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output cdms_pkg::cfg_type                cfg
);

   cdms_pkg::cfg_type cfg_ff;
   cdms_pkg::cfg_type cfg_in;
   cdms_pkg::reg_type reg_sel;
   logic              wr_en;

   assign reg_sel    = cdms_pkg::reg_type'(csr_paddr[2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            cdms_pkg::REG_FRAME_WIDTH:
               cfg_in.frame_width = csr_pwdata[cdms_pkg::FW_W-1:0];
            cdms_pkg::REG_FRAME_HEIGHT:
               cfg_in.frame_height = csr_pwdata[cdms_pkg::ROW_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width  <= cdms_pkg::FRAME_WIDTH_RESET;
         cfg_ff.frame_height <= cdms_pkg::FRAME_HEIGHT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux
   always_comb begin
      unique case (reg_sel)
         cdms_pkg::REG_FRAME_WIDTH:
            csr_prdata = cdms_pkg::CSR_DATA_W'(cfg_ff.frame_width);
         cdms_pkg::REG_FRAME_HEIGHT:
            csr_prdata = cdms_pkg::CSR_DATA_W'(cfg_ff.frame_height);
         default: csr_prdata = '0;
      endcase
   end

endmodule

// ===== rtl/cdms_line_window.sv =====
// Position counters, line store memory with read-modify-write, and the 3x3 window.
module cdms_line_window (
   input  logic                        clock,
   input  logic                        reset,
   input  cdms_pkg::cfg_type           cfg,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [cdms_pkg::PIX_W-1:0]  req_red_in,
   input  logic [cdms_pkg::PIX_W-1:0]  req_green_in,
   input  logic [cdms_pkg::PIX_W-1:0]  req_blue_in,
   input  logic                        req_frame_start,
   output logic                        win_valid,
   input  logic                        win_ready,
   output cdms_pkg::win_type           win
);

   localparam int ADDR_W = cdms_pkg::ADDR_W;
   localparam int FW_W   = cdms_pkg::FW_W;
   localparam int ROW_W  = cdms_pkg::ROW_W;
   localparam int COL_W  = cdms_pkg::COL_W;
   localparam int DIM    = cdms_pkg::WIN_DIM;

   // Line store: both rows above, one entry per column
   cdms_pkg::line_pair_type line_mem [cdms_pkg::MAX_WIDTH];

   logic [ADDR_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;

   logic                    s1_valid_ff;
   logic                    s1_emit_ff;
   logic [ADDR_W-1:0]       s1_addr_ff;
   logic [ROW_W-1:0]        s1_row_ff;
   logic [COL_W-1:0]        s1_col_ff;
   cdms_pkg::triple_type    s1_cur_ff;
   cdms_pkg::line_pair_type mem_q_ff;
   cdms_pkg::line_pair_type fwd_data_ff;
   logic                    fwd_ff;

   cdms_pkg::triple_type win_ff [DIM][DIM];
   cdms_pkg::triple_type win_in [DIM][DIM];

   logic [FW_W-1:0]         w_eff;
   logic [ROW_W-1:0]        h_eff;
   logic [ADDR_W-1:0]       col_cur;
   logic [ROW_W-1:0]        row_cur;
   logic [FW_W-1:0]         col_inc;
   logic [ROW_W:0]          row_inc;
   logic                    emit;
   logic                    accept;
   logic                    s1_go;
   cdms_pkg::triple_type    cur;
   cdms_pkg::line_pair_type line_rd;
   cdms_pkg::line_pair_type wr_data;

   // Effective frame size
   always_comb begin
      w_eff = cfg.frame_width;
      if (w_eff < cdms_pkg::FRAME_WIDTH_MIN) w_eff = cdms_pkg::FRAME_WIDTH_MIN;
      if (w_eff > FW_W'(cdms_pkg::MAX_WIDTH)) w_eff = FW_W'(cdms_pkg::MAX_WIDTH);
      h_eff = cfg.frame_height;
      if (h_eff < cdms_pkg::FRAME_HEIGHT_MIN) h_eff = cdms_pkg::FRAME_HEIGHT_MIN;
   end

   // Position of the incoming pixel, emission test and counter advance
   always_comb begin
      col_cur = req_frame_start ? '0 : col_ff;
      row_cur = req_frame_start ? '0 : row_ff;
      emit = (row_cur >= ROW_W'(2)) && (FW_W'(col_cur) >= FW_W'(2))
             && (FW_W'(col_cur) < w_eff) && (row_cur < h_eff);
      col_inc = FW_W'(col_cur) + FW_W'(1);
      row_inc = {1'b0, row_cur} + (ROW_W+1)'(1);
      col_in  = col_inc[ADDR_W-1:0];
      row_in  = row_cur;
      if (col_inc >= w_eff) begin
         col_in = '0;
         row_in = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[ROW_W-1:0];
      end
   end

   // Color differences of the incoming pixel
   always_comb begin
      cur.rd = $signed({1'b0, req_red_in}) - $signed({1'b0, req_green_in});
      cur.bd = $signed({1'b0, req_blue_in}) - $signed({1'b0, req_green_in});
      cur.g  = req_green_in;
   end

   assign s1_go     = s1_valid_ff && (!s1_emit_ff || win_ready);
   assign req_ready = !s1_valid_ff || s1_go;
   assign accept    = req_valid && req_ready;
   assign win_valid = s1_valid_ff && s1_emit_ff;

   // Read data, bypassed when the previous write hit the same entry on the read edge
   assign line_rd     = fwd_ff ? fwd_data_ff : mem_q_ff;
   assign wr_data.up  = line_rd.mid;
   assign wr_data.mid = s1_cur_ff;

   // Line store: read on accept, write back when the pixel leaves stage 1
   always_ff @(posedge clock) begin
      if (accept) mem_q_ff <= line_mem[col_cur];
      if (s1_go) line_mem[s1_addr_ff] <= wr_data;
   end

   // Counters, stage 1 control and bypass flag
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         if (accept) begin
            col_ff      <= col_in;
            row_ff      <= row_in;
            s1_valid_ff <= 1'b1;
            fwd_ff      <= s1_go && (s1_addr_ff == col_cur);
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   // Stage 1 payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_emit_ff  <= emit;
         s1_addr_ff  <= col_cur;
         s1_cur_ff   <= cur;
         s1_row_ff   <= row_cur - ROW_W'(1);
         s1_col_ff   <= COL_W'(col_cur) - COL_W'(1);
         fwd_data_ff <= wr_data;
      end
   end

   // Window shift: new column on the right is (row above above, row above, current)
   always_comb begin
      for (int k = 0; k < DIM; k++) begin
         for (int j = 0; j < DIM - 1; j++) begin
            win_in[k][j] = win_ff[k][j+1];
         end
      end
      win_in[0][DIM-1] = line_rd.up;
      win_in[1][DIM-1] = line_rd.mid;
      win_in[2][DIM-1] = s1_cur_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIM; k++) begin
            for (int j = 0; j < DIM; j++) begin
               win_ff[k][j] <= '0;
            end
         end
      end else if (s1_go) begin
         win_ff <= win_in;
      end
   end

   // Window handed on, taken after the shift
   always_comb begin
      for (int k = 0; k < DIM; k++) begin
         for (int j = 0; j < DIM; j++) begin
            win.rd[k*DIM+j] = win_in[k][j].rd;
            win.bd[k*DIM+j] = win_in[k][j].bd;
         end
      end
      win.gc  = win_in[1][1].g;
      win.row = s1_row_ff;
      win.col = s1_col_ff;
   end

endmodule

// ===== rtl/cdms_median.sv =====
// Three-stage median of nine pipeline, green add back and saturation, output register.
module cdms_median (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        win_valid,
   output logic                        win_ready,
   input  cdms_pkg::win_type           win,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [cdms_pkg::PIX_W-1:0]  rsp_red_out,
   output logic [cdms_pkg::PIX_W-1:0]  rsp_blue_out,
   output logic [cdms_pkg::ROW_W-1:0]  rsp_center_row,
   output logic [cdms_pkg::COL_W-1:0]  rsp_center_col
);

   localparam int PIX_W  = cdms_pkg::PIX_W;
   localparam int DIFF_W = cdms_pkg::DIFF_W;
   localparam int SUM_W  = cdms_pkg::SUM_W;
   localparam int DIM    = cdms_pkg::WIN_DIM;

   typedef struct packed {
      cdms_pkg::diff_type lo;
      cdms_pkg::diff_type md;
      cdms_pkg::diff_type hi;
   } sort3_type;

   function automatic cdms_pkg::diff_type dmin(cdms_pkg::diff_type a, cdms_pkg::diff_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic cdms_pkg::diff_type dmax(cdms_pkg::diff_type a, cdms_pkg::diff_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic cdms_pkg::diff_type med3(cdms_pkg::diff_type a, cdms_pkg::diff_type b,
                                               cdms_pkg::diff_type c);
      return dmax(dmin(a, b), dmin(dmax(a, b), c));
   endfunction

   function automatic sort3_type sort3(cdms_pkg::diff_type a, cdms_pkg::diff_type b,
                                       cdms_pkg::diff_type c);
      sort3_type s;
      s.lo = dmin(dmin(a, b), c);
      s.md = med3(a, b, c);
      s.hi = dmax(dmax(a, b), c);
      return s;
   endfunction

   // Median plus centre green, clamped to the pixel range
   function automatic logic [PIX_W-1:0] add_sat(cdms_pkg::diff_type m, logic [PIX_W-1:0] g);
      logic signed [SUM_W-1:0] s;
      logic [PIX_W-1:0]        r;
      s = $signed({{(SUM_W-DIFF_W){m[DIFF_W-1]}}, m})
          + $signed({{(SUM_W-PIX_W){1'b0}}, g});
      if (s[SUM_W-1]) r = '0;
      else if (|s[SUM_W-2:PIX_W]) r = '1;
      else r = s[PIX_W-1:0];
      return r;
   endfunction

   // Stage 2: each window column sorted
   logic                           s2_valid_ff;
   sort3_type [DIM-1:0]            s2_rd_ff, s2_bd_ff, s2_rd_in, s2_bd_in;
   logic [PIX_W-1:0]               s2_gc_ff;
   logic [cdms_pkg::ROW_W-1:0]     s2_row_ff;
   logic [cdms_pkg::COL_W-1:0]     s2_col_ff;
   // Stage 3: max of mins, median of medians, min of maxes
   logic                           s3_valid_ff;
   sort3_type                      s3_rd_ff, s3_bd_ff, s3_rd_in, s3_bd_in;
   logic [PIX_W-1:0]               s3_gc_ff;
   logic [cdms_pkg::ROW_W-1:0]     s3_row_ff;
   logic [cdms_pkg::COL_W-1:0]     s3_col_ff;
   // Output register
   logic                           rsp_valid_ff;
   logic [PIX_W-1:0]               rsp_red_ff, rsp_blue_ff;
   logic [cdms_pkg::ROW_W-1:0]     rsp_row_ff;
   logic [cdms_pkg::COL_W-1:0]     rsp_col_ff;

   logic s2_go, s3_go;

   assign s3_go     = s3_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign s2_go     = s2_valid_ff && (!s3_valid_ff || s3_go);
   assign win_ready = !s2_valid_ff || s2_go;

   always_comb begin
      for (int j = 0; j < DIM; j++) begin
         s2_rd_in[j] = sort3(win.rd[j], win.rd[DIM+j], win.rd[2*DIM+j]);
         s2_bd_in[j] = sort3(win.bd[j], win.bd[DIM+j], win.bd[2*DIM+j]);
      end
   end

   always_comb begin
      s3_rd_in.lo = dmax(dmax(s2_rd_ff[0].lo, s2_rd_ff[1].lo), s2_rd_ff[2].lo);
      s3_rd_in.md = med3(s2_rd_ff[0].md, s2_rd_ff[1].md, s2_rd_ff[2].md);
      s3_rd_in.hi = dmin(dmin(s2_rd_ff[0].hi, s2_rd_ff[1].hi), s2_rd_ff[2].hi);
      s3_bd_in.lo = dmax(dmax(s2_bd_ff[0].lo, s2_bd_ff[1].lo), s2_bd_ff[2].lo);
      s3_bd_in.md = med3(s2_bd_ff[0].md, s2_bd_ff[1].md, s2_bd_ff[2].md);
      s3_bd_in.hi = dmin(dmin(s2_bd_ff[0].hi, s2_bd_ff[1].hi), s2_bd_ff[2].hi);
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (win_ready) s2_valid_ff <= win_valid;
         if (!s3_valid_ff || s3_go) s3_valid_ff <= s2_go;
         if (s3_go) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // Payload stages
   always_ff @(posedge clock) begin
      if (win_valid && win_ready) begin
         s2_rd_ff  <= s2_rd_in;
         s2_bd_ff  <= s2_bd_in;
         s2_gc_ff  <= win.gc;
         s2_row_ff <= win.row;
         s2_col_ff <= win.col;
      end
      if (s2_go) begin
         s3_rd_ff  <= s3_rd_in;
         s3_bd_ff  <= s3_bd_in;
         s3_gc_ff  <= s2_gc_ff;
         s3_row_ff <= s2_row_ff;
         s3_col_ff <= s2_col_ff;
      end
      if (s3_go) begin
         rsp_red_ff  <= add_sat(med3(s3_rd_ff.lo, s3_rd_ff.md, s3_rd_ff.hi), s3_gc_ff);
         rsp_blue_ff <= add_sat(med3(s3_bd_ff.lo, s3_bd_ff.md, s3_bd_ff.hi), s3_gc_ff);
         rsp_row_ff  <= s3_row_ff;
         rsp_col_ff  <= s3_col_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red_out    = rsp_red_ff;
   assign rsp_blue_out   = rsp_blue_ff;
   assign rsp_center_row = rsp_row_ff;
   assign rsp_center_col = rsp_col_ff;

endmodule

// ===== rtl/color_difference_median_smoothing_top.sv =====
// rsp_valid follows the window's last pixel through stages 1, 2 and 3 and the output register.
// Throughput: one pixel per clock unless rsp_ready stalls; one line store read and write each.
// Border pixels give no result; the output register lets a new pixel in while a result waits.
// Reset (synchronous): clears position counters, window registers and pipeline valids, and
// sets frame_width to 4096 and frame_height to 3. The line store is not cleared.
module color_difference_median_smoothing_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [cdms_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [cdms_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [cdms_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [cdms_pkg::PIX_W-1:0]       req_red_in,
   input  logic [cdms_pkg::PIX_W-1:0]       req_green_in,
   input  logic [cdms_pkg::PIX_W-1:0]       req_blue_in,
   input  logic                             req_frame_start,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [cdms_pkg::PIX_W-1:0]       rsp_red_out,
   output logic [cdms_pkg::PIX_W-1:0]       rsp_blue_out,
   output logic [cdms_pkg::ROW_W-1:0]       rsp_center_row,
   output logic [cdms_pkg::COL_W-1:0]       rsp_center_col
);

   cdms_pkg::cfg_type cfg;
   cdms_pkg::win_type win;
   logic              win_valid;
   logic              win_ready;

   // Configuration registers
   cdms_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Line store and window
   cdms_line_window u_line_window (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_red_in      (req_red_in),
      .req_green_in    (req_green_in),
      .req_blue_in     (req_blue_in),
      .req_frame_start (req_frame_start),
      .win_valid       (win_valid),
      .win_ready       (win_ready),
      .win             (win)
   );

   // Median pipeline and output register
   cdms_median u_median (
      .clock          (clock),
      .reset          (reset),
      .win_valid      (win_valid),
      .win_ready      (win_ready),
      .win            (win),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red_out    (rsp_red_out),
      .rsp_blue_out   (rsp_blue_out),
      .rsp_center_row (rsp_center_row),
      .rsp_center_col (rsp_center_col)
   );

endmodule

// ===== rtl/cdms_checker.sv =====
// Port-level checks for the smoother and the bind that attaches them.
module cdms_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        csr_pready,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [cdms_pkg::PIX_W-1:0]  rsp_red_out,
   input logic [cdms_pkg::PIX_W-1:0]  rsp_blue_out,
   input logic [cdms_pkg::ROW_W-1:0]  rsp_center_row,
   input logic [cdms_pkg::COL_W-1:0]  rsp_center_col
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red_out)
         && $stable(rsp_blue_out) && $stable(rsp_center_row) && $stable(rsp_center_col))
      else $error("result changed while stalled");

   // Centers are never in row or column zero, nor at the all-ones row or column
   a_center_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_center_col != '0 && rsp_center_col != '1
         && rsp_center_row != '0 && rsp_center_row != '1)
      else $error("result centre on a frame border");

   // Config port never waits
   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");

   // After reset the pipeline is empty and open
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

endmodule

bind color_difference_median_smoothing_top cdms_checker u_cdms_checker (
   .clock          (clock),
   .reset          (reset),
   .csr_pready     (csr_pready),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_red_out    (rsp_red_out),
   .rsp_blue_out   (rsp_blue_out),
   .rsp_center_row (rsp_center_row),
   .rsp_center_col (rsp_center_col)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for the color difference median smoother: directed and random frames.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import cdms_pkg::*;

   localparam int LATENCY       = 4;
   localparam int STALL_LIMIT   = 2000;
   localparam int RANDOM_PHASES = 4;
   localparam int PHASE_PIXELS  = 70;
   localparam int PRINT_LIMIT   = 40;

   typedef struct {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic             start;
   } pixel_type;

   typedef struct {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] blue;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } smoothed_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [PIX_W-1:0]      req_red_in = '0;
   logic [PIX_W-1:0]      req_green_in = '0;
   logic [PIX_W-1:0]      req_blue_in = '0;
   logic                  req_frame_start = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [PIX_W-1:0]      rsp_red_out;
   logic [PIX_W-1:0]      rsp_blue_out;
   logic [ROW_W-1:0]      rsp_center_row;
   logic [COL_W-1:0]      rsp_center_col;

   // Stimulus and scoreboard state
   pixel_type    pixel_queue[$];
   smoothed_type smoothed_due[$];
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   int           pixels_queued = 0;
   int           pixels_taken = 0;
   int           results_seen = 0;
   int           reg_writes = 0;
   int           mismatches = 0;
   int           quiet_cycles = 0;

   // Predictor copy of the block: line stores, window, position and settings
   triple_type      upper_line [MAX_WIDTH] = '{default: '0};
   triple_type      middle_line [MAX_WIDTH] = '{default: '0};
   triple_type      window [WIN_DIM][WIN_DIM] = '{default: '0};
   int unsigned     col_pos = 0;
   int unsigned     row_pos = 0;
   logic [FW_W-1:0]  cfg_width = FRAME_WIDTH_RESET;
   logic [ROW_W-1:0] cfg_height = FRAME_HEIGHT_RESET;

   color_difference_median_smoothing_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_red_in      (req_red_in),
      .req_green_in    (req_green_in),
      .req_blue_in     (req_blue_in),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_red_out     (rsp_red_out),
      .rsp_blue_out    (rsp_blue_out),
      .rsp_center_row  (rsp_center_row),
      .rsp_center_col  (rsp_center_col)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [PIX_W-1:0] clamp_to_pixel(input int v);
      if (v < 0) return '0;
      if (v > 65535) return '1;
      return v[PIX_W-1:0];
   endfunction

   function automatic int median_of_nine(input int v[WIN_N]);
      int t;
      for (int i = 0; i < WIN_N - 1; i++)
         for (int j = 0; j < WIN_N - 1 - i; j++)
            if (v[j] > v[j+1]) begin
               t = v[j];
               v[j] = v[j+1];
               v[j+1] = t;
            end
      return v[WIN_N/2];
   endfunction

   // Advance the predictor by one pixel and queue the smoothed centre if the window is interior
   task automatic predict_smoothing(input pixel_type p);
      int unsigned  w, h, slot;
      triple_type   cur, up, mid;
      int           rd_set[WIN_N];
      int           bd_set[WIN_N];
      int           centre_g;
      smoothed_type res;
      w = cfg_width;
      if (w < 3) w = 3;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      h = cfg_height;
      if (h < 3) h = 3;
      if (p.start) begin
         col_pos = 0;
         row_pos = 0;
      end
      cur.rd = diff_type'(int'(p.red) - int'(p.green));
      cur.bd = diff_type'(int'(p.blue) - int'(p.green));
      cur.g  = p.green;
      slot = col_pos % MAX_WIDTH;
      up  = upper_line[slot];
      mid = middle_line[slot];
      upper_line[slot]  = mid;
      middle_line[slot] = cur;
      for (int k = 0; k < WIN_DIM; k++) begin
         window[k][0] = window[k][1];
         window[k][1] = window[k][2];
      end
      window[0][2] = up;
      window[1][2] = mid;
      window[2][2] = cur;
      if (row_pos >= 2 && col_pos >= 2 && col_pos < w && row_pos < h) begin
         for (int k = 0; k < WIN_N; k++) begin
            rd_set[k] = window[k/WIN_DIM][k%WIN_DIM].rd;
            bd_set[k] = window[k/WIN_DIM][k%WIN_DIM].bd;
         end
         centre_g = window[1][1].g;
         res.red  = clamp_to_pixel(median_of_nine(rd_set) + centre_g);
         res.blue = clamp_to_pixel(median_of_nine(bd_set) + centre_g);
         res.row  = ROW_W'(row_pos - 1);
         res.col  = COL_W'(col_pos - 1);
         smoothed_due.push_back(res);
      end
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h) row_pos = 0;
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatches < PRINT_LIMIT)
         $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // Pixel driver: next pixel once the current one is transferred, with random gaps
   always @(posedge clock) begin : drive_pixels
      pixel_type p;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            p = pixel_queue.pop_front();
            req_valid       <= 1'b1;
            req_red_in      <= p.red;
            req_green_in    <= p.green;
            req_blue_in     <= p.blue;
            req_frame_start <= p.start;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Monitor: predict on each pixel transfer, check each result transfer
   always @(posedge clock) begin : watch_ports
      pixel_type    p;
      smoothed_type want;
      string        where;
      if (!reset) begin
         if (req_valid && req_ready) begin
            p.red   = req_red_in;
            p.green = req_green_in;
            p.blue  = req_blue_in;
            p.start = req_frame_start;
            predict_smoothing(p);
            pixels_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (smoothed_due.size() == 0) begin
               report_mismatch("unexpected result, center_row", rsp_center_row, -1);
            end else begin
               want = smoothed_due.pop_front();
               where = $sformatf("at row %0d col %0d", want.row, want.col);
               if (rsp_red_out !== want.red)
                  report_mismatch({"red_out ", where}, rsp_red_out, want.red);
               if (rsp_blue_out !== want.blue)
                  report_mismatch({"blue_out ", where}, rsp_blue_out, want.blue);
               if (rsp_center_row !== want.row)
                  report_mismatch("center_row", rsp_center_row, want.row);
               if (rsp_center_col !== want.col)
                  report_mismatch("center_col", rsp_center_col, want.col);
            end
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Register write: setup cycle, then access cycle until pready
   task automatic write_register(input reg_type which, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {which, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (which == REG_FRAME_WIDTH) cfg_width = value[FW_W-1:0];
      else cfg_height = value[ROW_W-1:0];
      reg_writes++;
   endtask

   // Wait until every pixel is transferred and every result is back, then let the pipe drain
   task automatic settle();
      while (pixels_taken != pixels_queued || smoothed_due.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic push_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                             input logic [PIX_W-1:0] b, input logic start);
      pixel_type p;
      p.red   = r;
      p.green = g;
      p.blue  = b;
      p.start = start;
      pixel_queue.push_back(p);
      pixels_queued++;
   endtask

   // Mostly correlated channels so medians stay in range, plus full random and rail values
   function automatic pixel_type random_pixel();
      pixel_type p;
      int        style, base;
      style = $urandom_range(99);
      if (style < 20) begin
         p.red   = PIX_W'($urandom);
         p.green = PIX_W'($urandom);
         p.blue  = PIX_W'($urandom);
      end else if (style < 30) begin
         p.red   = $urandom_range(1) ? '1 : '0;
         p.green = $urandom_range(1) ? '1 : '0;
         p.blue  = $urandom_range(1) ? '1 : '0;
      end else begin
         base    = $urandom_range(65535);
         p.green = PIX_W'(base);
         p.red   = clamp_to_pixel(base + int'($urandom_range(4000)) - 2000);
         p.blue  = clamp_to_pixel(base + int'($urandom_range(4000)) - 2000);
      end
      p.start = 1'b0;
      return p;
   endfunction

   // Pixel stream opening a new frame, with occasional early frame restarts
   task automatic push_stream(input int count, input int restart_pct);
      pixel_type p;
      for (int i = 0; i < count; i++) begin
         p = random_pixel();
         p.start = (i == 0) || ($urandom_range(99) < restart_pct);
         push_pixel(p.red, p.green, p.blue, p.start);
      end
   endtask

   // One random frame geometry, clamped settings included
   task automatic run_random_phase(input int count);
      int sel;
      logic [CSR_DATA_W-1:0] w, h;
      settle();
      sel = $urandom_range(99);
      if (sel < 10) w = $urandom_range(2);
      else if (sel < 25) w = 3;
      else if (sel < 85) w = $urandom_range(16, 4);
      else w = $urandom_range(40, 17);
      sel = $urandom_range(99);
      if (sel < 10) h = $urandom_range(2);
      else h = $urandom_range(8, 3);
      write_register(REG_FRAME_WIDTH, w);
      write_register(REG_FRAME_HEIGHT, h);
      push_stream(count, 2);
   endtask

   initial begin : run_stimulus
      pixel_type p;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: 3x3 frame (clamped settings) whose red median saturates high
      send_idle_pct = 29;
      recv_idle_pct = 68;
      write_register(REG_FRAME_WIDTH, 0);
      write_register(REG_FRAME_HEIGHT, 2);
      for (int i = 0; i < 9; i++) begin
         if (i == 4) push_pixel('1, '1, '0, 1'b0);
         else if (i <= 5) push_pixel('1, '0, '0, i == 0);
         else push_pixel('0, '1, '1, 1'b0);
      end

      // Wider frame entered by wrap-around, no frame_start; both medians clamp at zero
      settle();
      write_register(REG_FRAME_WIDTH, 4);
      write_register(REG_FRAME_HEIGHT, 4);
      for (int i = 0; i < 11; i++) begin
         if (i == 5) push_pixel('0, '0, '1, 1'b0);
         else push_pixel('0, '1, '0, 1'b0);
      end

      // Shrink width, then height, while the position is past the new limits
      settle();
      write_register(REG_FRAME_WIDTH, 3);
      p = random_pixel();
      push_pixel(p.red, p.green, p.blue, 1'b0);
      settle();
      write_register(REG_FRAME_HEIGHT, 3);
      for (int i = 0; i < 3; i++) begin
         p = random_pixel();
         push_pixel(p.red, p.green, p.blue, 1'b0);
      end
      // Restart in the middle of a frame
      p = random_pixel();
      push_pixel(p.red, p.green, p.blue, 1'b1);

      // Random frames under three idling patterns
      for (int mode = 0; mode < 3; mode++) begin
         if (mode == 1) begin
            send_idle_pct = 68;
            recv_idle_pct = 29;
         end else if (mode == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int ph = 0; ph < RANDOM_PHASES; ph++) run_random_phase(PHASE_PIXELS);
         if (mode == 1) begin
            // Tallest height setting, narrow frame, first rows only
            settle();
            write_register(REG_FRAME_WIDTH, 3);
            write_register(REG_FRAME_HEIGHT, 65535);
            push_stream(60, 0);
         end else if (mode == 2) begin
            // Over-range width setting clamps to full width; part of the first row only
            settle();
            write_register(REG_FRAME_WIDTH, 8191);
            write_register(REG_FRAME_HEIGHT, 3);
            push_stream(200, 0);
            settle();
            write_register(REG_FRAME_WIDTH, MAX_WIDTH);
            push_stream(20, 0);
            run_random_phase(PHASE_PIXELS);
         end
      end

      settle();
      $display("Checked %0d smoothed results from %0d pixels over %0d register writes;",
               results_seen, pixels_taken, reg_writes);
      $display("widths 3 to 4096 incl. clamped values, mid-frame restarts and stalls.");
      if (mismatches == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
